// ===== rtl/core/sprs_pkg.sv =====
// Shared constants, codes and types of the slotted page record store.
package sprs_pkg;

   localparam int PAGE_BYTES = 4096;
   localparam int MAX_SLOTS  = 256;
   localparam int PAGE_AW    = $clog2(PAGE_BYTES);
   localparam int SLOT_AW    = $clog2(MAX_SLOTS);
   localparam int LEN_W      = PAGE_AW + 1;
   localparam int CNT_W      = SLOT_AW + 1;
   localparam int ENTRY_W    = 2 * LEN_W + 1;

   typedef enum logic [2:0] {
      OP_INSERT  = 3'd0,
      OP_READ    = 3'd1,
      OP_UPDATE  = 3'd2,
      OP_REMOVE  = 3'd3,
      OP_COMPACT = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      STAT_OK         = 3'd0,
      STAT_PAGE_FULL  = 3'd1,
      STAT_BAD_SLOT   = 3'd2,
      STAT_DELETED    = 3'd3,
      STAT_TABLE_FULL = 3'd4,
      STAT_BAD_INDEX  = 3'd5
   } status_type;

   typedef struct packed {
      logic             del;
      logic [LEN_W-1:0] len;
      logic [LEN_W-1:0] off;
   } slot_entry_type;

endpackage

// ===== rtl/core/sprs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module sprs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/slotted_page_record_store_unit.sv =====
// Slotted page record store: page byte memory, slot table memory and control.
//
// Usage: drive req_* and raise start; the item is taken at a clock edge where
// start is high and busy is low. Every item yields one result: rsp_valid is
// high for one cycle with rsp_* carrying it, and the receiver cannot stall it.
// Insert and update stream a record one byte per item; the first item of a
// record allocates or resizes the slot, last closes the record.
// Sequence: each item first reads its slot table entry; a read byte then reads
// the page; an update that relocates the record marks the old slot deleted in
// a second table write, and the next item waits for that write. Compact walks
// the slots, skips deleted ones, rewrites each live record's offset and copies
// its bytes toward the front, one byte read then written at a time.
// The slot table and page bytes sit in two synchronous RAMs with registered
// read data; each item reads its slot entry before it acts.
// Reset (synchronous, active high) empties the page: free pointer, slot count,
// dirty flag and open record clear; memory contents are left as they are.
module slotted_page_record_store_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [2:0]                  req_op,
   input  logic [7:0]                  req_slot,
   input  logic [12:0]                 req_length,
   input  logic [11:0]                 req_byte_index,
   input  logic [7:0]                  req_data_byte,
   input  logic                        req_last,
   output logic                        rsp_valid,
   output logic [2:0]                  rsp_status,
   output logic [7:0]                  rsp_slot_id,
   output logic                        rsp_relocated,
   output logic [7:0]                  rsp_read_byte,
   output logic [12:0]                 rsp_record_length,
   output logic                        rsp_dirty
);
   import sprs_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_LOOK, S_READ, S_MARK, S_CRD, S_CENT, S_CPRD, S_CPWR
   } state_type;

   typedef enum logic [1:0] {
      MODE_IDLE, MODE_INSERT, MODE_UPDATE
   } mode_type;

   state_type        state_ff, state_in;
   mode_type         mode_ff, mode_in;
   logic [2:0]       op_ff, op_in;
   logic [7:0]       slot_ff, slot_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [11:0]      bidx_ff, bidx_in;
   logic [7:0]       data_ff, data_in;
   logic             last_ff, last_in;
   logic             cont_ff, cont_in;
   logic [LEN_W-1:0] free_ff, free_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic             dirty_ff, dirty_in;
   logic [LEN_W-1:0] cursor_ff, cursor_in;
   logic [7:0]       rslot_ff, rslot_in;
   slot_entry_type   old_ent_ff, old_ent_in;
   logic [CNT_W-1:0] ci_ff, ci_in;
   logic [LEN_W-1:0] wpos_ff, wpos_in;
   logic [LEN_W-1:0] coff_ff, coff_in;
   logic [LEN_W-1:0] clen_ff, clen_in;
   logic [LEN_W-1:0] k_ff, k_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_status_ff, rsp_status_in;
   logic [7:0]       rsp_slot_ff, rsp_slot_in;
   logic             rsp_rel_ff, rsp_rel_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic [LEN_W-1:0] rsp_len_ff, rsp_len_in;

   logic               tbl_we;
   logic [SLOT_AW-1:0] tbl_waddr, tbl_raddr;
   slot_entry_type     tbl_wdata, ent;
   logic [ENTRY_W-1:0] tbl_rdata;
   logic               pg_we;
   logic [PAGE_AW-1:0] pg_waddr, pg_raddr;
   logic [7:0]         pg_wdata, pg_rdata;

   logic               cont_now, slot_bad, inplace;
   logic [2:0]         alloc_st;
   logic [LEN_W-1:0]   pb_off, pb_len, pb_cur, pb_addr;
   logic               pb_del, pb_take;
   logic [LEN_W:0]     fit_sum;
   logic [LEN_W-1:0]   k_next;

   sprs_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SLOTS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_addr (tbl_raddr),
      .rd_data (tbl_rdata)
   );

   sprs_ram #(.WIDTH(8), .DEPTH(PAGE_BYTES)) u_page_ram (
      .clock   (clock),
      .wr_en   (pg_we),
      .wr_addr (pg_waddr),
      .wr_data (pg_wdata),
      .rd_addr (pg_raddr),
      .rd_data (pg_rdata)
   );

   assign ent      = slot_entry_type'(tbl_rdata);
   assign cont_now = (req_op == OP_INSERT && mode_ff == MODE_INSERT) ||
                     (req_op == OP_UPDATE && mode_ff == MODE_UPDATE);
   assign slot_bad = {1'b0, slot_ff} >= used_ff;
   assign inplace  = len_ff <= ent.len;
   assign fit_sum  = {1'b0, free_ff} + {1'b0, len_ff};

   always_comb begin
      if (used_ff >= CNT_W'(MAX_SLOTS)) begin
         alloc_st = STAT_TABLE_FULL;
      end else if (fit_sum > (LEN_W+1)'(PAGE_BYTES)) begin
         alloc_st = STAT_PAGE_FULL;
      end else begin
         alloc_st = STAT_OK;
      end
   end

   // byte placement for the record item in hand: open record, slot updated in place or freshly made slot
   always_comb begin
      pb_off  = (cont_ff || (op_ff == OP_UPDATE && inplace)) ? ent.off : free_ff;
      pb_len  = cont_ff ? ent.len : len_ff;
      pb_del  = cont_ff ? ent.del : 1'b0;
      pb_cur  = cont_ff ? cursor_ff : '0;
      pb_take = pb_cur < pb_len;
      pb_addr = pb_off + pb_cur;
   end

   assign k_next = k_ff + LEN_W'(1);

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      op_in         = op_ff;
      slot_in       = slot_ff;
      len_in        = len_ff;
      bidx_in       = bidx_ff;
      data_in       = data_ff;
      last_in       = last_ff;
      cont_in       = cont_ff;
      free_in       = free_ff;
      used_in       = used_ff;
      dirty_in      = dirty_ff;
      cursor_in     = cursor_ff;
      rslot_in      = rslot_ff;
      old_ent_in    = old_ent_ff;
      ci_in         = ci_ff;
      wpos_in       = wpos_ff;
      coff_in       = coff_ff;
      clen_in       = clen_ff;
      k_in          = k_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_rel_in    = rsp_rel_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_len_in    = rsp_len_ff;
      tbl_we        = 1'b0;
      tbl_waddr     = slot_ff;
      tbl_wdata     = ent;
      tbl_raddr     = cont_now ? rslot_ff : req_slot;
      pg_we         = 1'b0;
      pg_waddr      = pb_addr[PAGE_AW-1:0];
      pg_wdata      = data_ff;
      pg_raddr      = pb_addr[PAGE_AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req_op;
               slot_in  = req_slot;
               len_in   = req_length;
               bidx_in  = req_byte_index;
               data_in  = req_data_byte;
               last_in  = req_last;
               cont_in  = cont_now;
               state_in = S_LOOK;
            end
         end

         S_LOOK: begin
            state_in      = S_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_status_in = STAT_OK;
            rsp_slot_in   = slot_ff;
            rsp_rel_in    = 1'b0;
            rsp_byte_in   = '0;
            rsp_len_in    = '0;
            if ((op_ff == OP_INSERT || op_ff == OP_UPDATE) && cont_ff) begin
               // continue the open record
               if (pb_take) begin
                  if (!pb_del) begin
                     pg_we    = 1'b1;
                     dirty_in = 1'b1;
                  end
                  cursor_in = pb_cur + LEN_W'(1);
               end
               if (last_ff) begin
                  mode_in = MODE_IDLE;
               end
               rsp_slot_in = rslot_ff;
               rsp_len_in  = ent.len;
            end else begin
               unique case (op_ff)
                  OP_INSERT: begin
                     mode_in = MODE_IDLE;
                     if (alloc_st != STAT_OK) begin
                        rsp_status_in = alloc_st;
                        rsp_slot_in   = '0;
                     end else begin
                        tbl_we      = 1'b1;
                        tbl_waddr   = used_ff[SLOT_AW-1:0];
                        tbl_wdata   = '{del: 1'b0, len: len_ff, off: free_ff};
                        used_in     = used_ff + CNT_W'(1);
                        free_in     = fit_sum[LEN_W-1:0];
                        dirty_in    = 1'b1;
                        rslot_in    = used_ff[SLOT_AW-1:0];
                        pg_we       = pb_take;
                        cursor_in   = pb_take ? LEN_W'(1) : '0;
                        mode_in     = last_ff ? MODE_IDLE : MODE_INSERT;
                        rsp_slot_in = used_ff[SLOT_AW-1:0];
                        rsp_len_in  = len_ff;
                     end
                  end
                  OP_READ: begin
                     if (slot_bad) begin
                        rsp_status_in = STAT_BAD_SLOT;
                     end else if (ent.del) begin
                        rsp_status_in = STAT_DELETED;
                        rsp_len_in    = ent.len;
                     end else if ({1'b0, bidx_ff} >= ent.len) begin
                        rsp_status_in = STAT_BAD_INDEX;
                        rsp_len_in    = ent.len;
                     end else begin
                        // hold the result until the page byte returns
                        rsp_valid_in = 1'b0;
                        rsp_len_in   = ent.len;
                        pg_raddr     = PAGE_AW'(ent.off + {1'b0, bidx_ff});
                        state_in     = S_READ;
                     end
                  end
                  OP_UPDATE: begin
                     mode_in = MODE_IDLE;
                     if (slot_bad) begin
                        rsp_status_in = STAT_BAD_SLOT;
                     end else if (ent.del) begin
                        rsp_status_in = STAT_DELETED;
                        rsp_len_in    = ent.len;
                     end else if (inplace) begin
                        tbl_we     = 1'b1;
                        tbl_waddr  = slot_ff;
                        tbl_wdata  = '{del: 1'b0, len: len_ff, off: ent.off};
                        dirty_in   = 1'b1;
                        rslot_in   = slot_ff;
                        pg_we      = pb_take;
                        cursor_in  = pb_take ? LEN_W'(1) : '0;
                        mode_in    = last_ff ? MODE_IDLE : MODE_UPDATE;
                        rsp_len_in = len_ff;
                     end else if (alloc_st != STAT_OK) begin
                        rsp_status_in = alloc_st;
                        rsp_len_in    = ent.len;
                     end else begin
                        tbl_we      = 1'b1;
                        tbl_waddr   = used_ff[SLOT_AW-1:0];
                        tbl_wdata   = '{del: 1'b0, len: len_ff, off: free_ff};
                        used_in     = used_ff + CNT_W'(1);
                        free_in     = fit_sum[LEN_W-1:0];
                        dirty_in    = 1'b1;
                        rslot_in    = used_ff[SLOT_AW-1:0];
                        pg_we       = pb_take;
                        cursor_in   = pb_take ? LEN_W'(1) : '0;
                        mode_in     = last_ff ? MODE_IDLE : MODE_UPDATE;
                        old_ent_in  = '{del: 1'b1, len: ent.len, off: ent.off};
                        state_in    = S_MARK;
                        rsp_slot_in = used_ff[SLOT_AW-1:0];
                        rsp_rel_in  = 1'b1;
                        rsp_len_in  = len_ff;
                     end
                  end
                  OP_REMOVE: begin
                     mode_in = MODE_IDLE;
                     if (slot_bad) begin
                        rsp_status_in = STAT_BAD_SLOT;
                     end else begin
                        tbl_we     = 1'b1;
                        tbl_waddr  = slot_ff;
                        tbl_wdata  = '{del: 1'b1, len: ent.len, off: ent.off};
                        dirty_in   = 1'b1;
                        rsp_len_in = ent.len;
                     end
                  end
                  OP_COMPACT: begin
                     mode_in      = MODE_IDLE;
                     rsp_valid_in = 1'b0;
                     ci_in        = '0;
                     wpos_in      = '0;
                     state_in     = S_CRD;
                  end
                  default: begin
                     rsp_slot_in = '0;
                  end
               endcase
            end
         end

         S_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = STAT_OK;
            rsp_slot_in   = slot_ff;
            rsp_rel_in    = 1'b0;
            rsp_byte_in   = pg_rdata;
            state_in      = S_IDLE;
         end

         S_MARK: begin
            tbl_we    = 1'b1;
            tbl_waddr = slot_ff;
            tbl_wdata = old_ent_ff;
            state_in  = S_IDLE;
         end

         S_CRD: begin
            tbl_raddr = ci_ff[SLOT_AW-1:0];
            if (ci_ff == used_ff) begin
               free_in       = wpos_ff;
               dirty_in      = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_slot_in   = '0;
               rsp_rel_in    = 1'b0;
               rsp_byte_in   = '0;
               rsp_len_in    = '0;
               state_in      = S_IDLE;
            end else begin
               state_in = S_CENT;
            end
         end

         S_CENT: begin
            if (ent.del) begin
               ci_in    = ci_ff + CNT_W'(1);
               state_in = S_CRD;
            end else if (ent.len == '0) begin
               tbl_we    = 1'b1;
               tbl_waddr = ci_ff[SLOT_AW-1:0];
               tbl_wdata = '{del: 1'b0, len: ent.len, off: wpos_ff};
               ci_in     = ci_ff + CNT_W'(1);
               state_in  = S_CRD;
            end else begin
               coff_in  = ent.off;
               clen_in  = ent.len;
               k_in     = '0;
               state_in = S_CPRD;
            end
         end

         S_CPRD: begin
            pg_raddr = PAGE_AW'(coff_ff + k_ff);
            state_in = S_CPWR;
         end

         S_CPWR: begin
            // live records only move toward the front, so copy in place
            pg_we    = 1'b1;
            pg_waddr = PAGE_AW'(wpos_ff + k_ff);
            pg_wdata = pg_rdata;
            k_in     = k_next;
            if (k_next == clen_ff) begin
               tbl_we    = 1'b1;
               tbl_waddr = ci_ff[SLOT_AW-1:0];
               tbl_wdata = '{del: 1'b0, len: clen_ff, off: wpos_ff};
               wpos_in   = wpos_ff + clen_ff;
               ci_in     = ci_ff + CNT_W'(1);
               state_in  = S_CRD;
            end else begin
               state_in = S_CPRD;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_IDLE;
         free_ff      <= '0;
         used_ff      <= '0;
         dirty_ff     <= 1'b0;
         cursor_ff    <= '0;
         rslot_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         free_ff      <= free_in;
         used_ff      <= used_in;
         dirty_ff     <= dirty_in;
         cursor_ff    <= cursor_in;
         rslot_ff     <= rslot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      slot_ff       <= slot_in;
      len_ff        <= len_in;
      bidx_ff       <= bidx_in;
      data_ff       <= data_in;
      last_ff       <= last_in;
      cont_ff       <= cont_in;
      old_ent_ff    <= old_ent_in;
      ci_ff         <= ci_in;
      wpos_ff       <= wpos_in;
      coff_ff       <= coff_in;
      clen_ff       <= clen_in;
      k_ff          <= k_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_rel_ff    <= rsp_rel_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_len_ff    <= rsp_len_in;
   end

   assign busy              = state_ff != S_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slot_id       = rsp_slot_ff;
   assign rsp_relocated     = rsp_rel_ff;
   assign rsp_read_byte     = rsp_byte_ff;
   assign rsp_record_length = rsp_len_ff;
   assign rsp_dirty         = dirty_ff;

endmodule
